>>> rtl/sct_pkg.sv
// Shared types, constants and character helpers for the source code tokenizer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

  localparam int unsigned LINE_WIDTH   = 16;
  localparam int unsigned OFFSET_WIDTH = 24;
  localparam int unsigned WINDOW       = 7;
  localparam int unsigned NUM_KW       = 18;
  localparam int unsigned MAX_TOKENS   = 3;

  localparam logic [15:0] LEN_CAP   = 16'hFFFF;
  localparam logic [62:0] VALUE_CAP = {63{1'b1}};

  // token codes, keywords first in table order
  typedef enum logic [5:0] {
    K_DOUBLE = 6'd0, K_DOUBLE_OPT, K_ELSE, K_FUNC, K_IF, K_INT_KW, K_INT_OPT, K_LET,
    K_NIL, K_RETURN, K_STRING_KW, K_STRING_OPT, K_VAR, K_WHILE, K_TRUE, K_FALSE,
    K_BOOL, K_BOOL_OPT, K_IDENT, K_INT, K_FLOAT, K_STRING, K_DIV, K_ADD, K_SUB,
    K_ARROW, K_MUL, K_NOT, K_EXCL, K_NE, K_ASSIGN, K_EQ, K_GT, K_LT, K_GE, K_LE,
    K_LPAR, K_RPAR, K_LBRACE, K_RBRACE, K_COLON, K_COMMA, K_UNDER, K_OR, K_AND,
    K_NILC, K_LINECOM, K_BLOCKCOM, K_END, K_ERROR
  } token_kind_e;

  // scanner modes, one-hot
  typedef enum logic [25:0] {
    M_START  = 26'h0000001, M_SLASH  = 26'h0000002, M_LINE   = 26'h0000004,
    M_BLOCK  = 26'h0000008, M_BSTAR  = 26'h0000010, M_BSLASH = 26'h0000020,
    M_SUB    = 26'h0000040, M_EXCL   = 26'h0000080, M_ASSIGN = 26'h0000100,
    M_GT     = 26'h0000200, M_LT     = 26'h0000400, M_UNDER  = 26'h0000800,
    M_IDENT  = 26'h0001000, M_INT    = 26'h0002000, M_DOT    = 26'h0004000,
    M_FRAC   = 26'h0008000, M_EMARK  = 26'h0010000, M_ESIGN  = 26'h0020000,
    M_EXP    = 26'h0040000, M_STR    = 26'h0080000, M_ESC    = 26'h0100000,
    M_UNI_U  = 26'h0200000, M_UNI_HEX = 26'h0400000, M_QUEST = 26'h0800000,
    M_OR     = 26'h1000000, M_AND    = 26'h2000000
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] line_number;
    logic        newline_before;
    logic [23:0] start_offset;
    logic [15:0] token_length;
    logic [62:0] integer_value;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    lex_mode_e                     mode;
    logic [WINDOW-1:0][7:0]        window;
    logic [15:0]                   wlen;
    logic [62:0]                   acc;
    logic [LINE_WIDTH-1:0]         line;
    logic [OFFSET_WIDTH-1:0]       offset;
    logic [OFFSET_WIDTH-1:0]       tstart;
    logic                          nl;
  } lex_state_t;

  // keyword text, first byte in the top byte, zero padded
  localparam logic [55:0] KW_TEXT [NUM_KW] = '{
    {"Double", 8'h00}, "Double?", {"else", 24'h0}, {"func", 24'h0}, {"if", 40'h0},
    {"Int", 32'h0}, {"Int?", 24'h0}, {"let", 32'h0}, {"nil", 32'h0},
    {"return", 8'h00}, {"String", 8'h00}, "String?", {"var", 32'h0},
    {"while", 16'h0}, {"true", 24'h0}, {"false", 16'h0}, {"Bool", 24'h0},
    {"Bool?", 16'h0}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd6, 3'd7, 3'd4, 3'd4, 3'd2, 3'd3, 3'd4, 3'd3, 3'd3, 3'd6, 3'd6, 3'd7, 3'd3,
    3'd5, 3'd4, 3'd5, 3'd4, 3'd5
  };

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == "_");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'h20, 8'h00, 8'h09, 8'h0B, 8'h0C, 8'h0D};
  endfunction

  function automatic logic [LINE_WIDTH-1:0] line_inc(input logic [LINE_WIDTH-1:0] l);
    return (l != {LINE_WIDTH{1'b1}}) ? l + 1'b1 : l;
  endfunction

  // open a token at the current offset
  function automatic lex_state_t begin_tok(input lex_state_t s);
    lex_state_t r;
    r        = s;
    r.tstart = s.offset;
    r.wlen   = '0;
    r.acc    = '0;
    return r;
  endfunction

  // append one byte to the current token
  function automatic lex_state_t take_byte(input lex_state_t s, input logic [7:0] c);
    lex_state_t r;
    r = s;
    if (s.wlen < 16'(WINDOW)) r.window[s.wlen[2:0]] = c;
    if (s.wlen != LEN_CAP) r.wlen = s.wlen + 16'd1;
    if (c == 8'h0A) r.line = line_inc(s.line);
    return r;
  endfunction

  // keyword lookup over the first bytes of a word
  function automatic token_kind_e word_kind(input logic [WINDOW-1:0][7:0] w,
                                            input logic [15:0] len);
    token_kind_e k;
    logic        hit;
    logic        found;
    k     = K_IDENT;
    found = 1'b0;
    if (len <= 16'(WINDOW)) begin
      for (int i = 0; i < NUM_KW; i++) begin
        hit = (16'(KW_LEN[i]) == len);
        for (int j = 0; j < WINDOW; j++) begin
          if ((16'(j) < len) && (w[j] != KW_TEXT[i][55-8*j -: 8])) hit = 1'b0;
        end
        if (hit && !found) begin
          k     = token_kind_e'(6'(i));
          found = 1'b1;
        end
      end
    end
    return k;
  endfunction

  // decimal accumulate with saturation
  function automatic logic [62:0] acc_step(input logic [62:0] acc, input logic [7:0] c);
    logic [66:0] p;
    p = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {63'b0, c[3:0]};
    return (p > {4'b0, VALUE_CAP}) ? VALUE_CAP : p[62:0];
  endfunction

  function automatic out_t make_token(input lex_state_t s, input token_kind_e k,
                                      input logic [62:0] v);
    out_t t;
    t.token_kind     = k;
    t.line_number    = 16'(s.line);
    t.newline_before = s.nl;
    t.start_offset   = 24'(s.tstart);
    t.token_length   = s.wlen;
    t.integer_value  = v;
    t.last_of_run    = 1'b0;
    return t;
  endfunction

endpackage

`default_nettype wire

>>> rtl/sct_lex_step.sv
// One scanning pass of the tokenizer: examines a byte in the current mode.
// Combinational; uses sct_pkg types and helpers.
`timescale 1ns / 1ps
`default_nettype none

module sct_lex_step #(
  parameter int unsigned MAX_NEST       = 255,
  parameter int unsigned MAX_HEX_DIGITS = 8,
  localparam int unsigned DepthW        = $clog2(MAX_NEST + 1),
  localparam int unsigned HexW          = $clog2(MAX_HEX_DIGITS + 1)
) (
  input  wire logic                  act_i,
  input  wire logic [7:0]            c_i,
  input  wire logic                  eoi_i,
  input  wire sct_pkg::lex_state_t   st_i,
  input  wire logic [DepthW-1:0]     depth_i,
  input  wire logic [HexW-1:0]       hex_i,
  output sct_pkg::lex_state_t        st_o,
  output logic [DepthW-1:0]          depth_o,
  output logic [HexW-1:0]            hex_o,
  output logic                       emit_o,
  output sct_pkg::out_t              tok_o,
  output logic                       again_o
);

  logic                 fin_emit;
  sct_pkg::token_kind_e fin_kind;
  logic [62:0]          fin_val;
  logic                 is_pair;
  logic [7:0]           pair_want;
  sct_pkg::token_kind_e pair_kind;

  // what completing the pending token gives
  always_comb begin
    fin_emit = 1'b1;
    fin_kind = sct_pkg::K_ERROR;
    fin_val  = '0;
    case (st_i.mode)
      sct_pkg::M_START:  fin_emit = 1'b0;
      sct_pkg::M_SLASH:  fin_kind = sct_pkg::K_DIV;
      sct_pkg::M_SUB:    fin_kind = sct_pkg::K_SUB;
      sct_pkg::M_EXCL:   fin_kind = sct_pkg::K_EXCL;
      sct_pkg::M_ASSIGN: fin_kind = sct_pkg::K_ASSIGN;
      sct_pkg::M_GT:     fin_kind = sct_pkg::K_GT;
      sct_pkg::M_LT:     fin_kind = sct_pkg::K_LT;
      sct_pkg::M_UNDER:  fin_kind = sct_pkg::K_IDENT;
      sct_pkg::M_IDENT:  fin_kind = sct_pkg::word_kind(st_i.window, st_i.wlen);
      sct_pkg::M_INT: begin
        fin_kind = sct_pkg::K_INT;
        fin_val  = st_i.acc;
      end
      sct_pkg::M_FRAC:   fin_kind = sct_pkg::K_FLOAT;
      sct_pkg::M_EXP:    fin_kind = sct_pkg::K_FLOAT;
      sct_pkg::M_LINE:   fin_kind = sct_pkg::K_LINECOM;
      default:           fin_kind = sct_pkg::K_ERROR;
    endcase
  end

  // two-byte operators: second byte wanted and resulting code
  always_comb begin
    is_pair   = 1'b1;
    pair_want = "=";
    pair_kind = sct_pkg::K_ERROR;
    case (st_i.mode)
      sct_pkg::M_SUB: begin
        pair_want = ">";
        pair_kind = sct_pkg::K_ARROW;
      end
      sct_pkg::M_EXCL:   pair_kind = sct_pkg::K_NE;
      sct_pkg::M_ASSIGN: pair_kind = sct_pkg::K_EQ;
      sct_pkg::M_GT:     pair_kind = sct_pkg::K_GE;
      sct_pkg::M_LT:     pair_kind = sct_pkg::K_LE;
      sct_pkg::M_QUEST: begin
        pair_want = "?";
        pair_kind = sct_pkg::K_NILC;
      end
      sct_pkg::M_OR: begin
        pair_want = "|";
        pair_kind = sct_pkg::K_OR;
      end
      sct_pkg::M_AND: begin
        pair_want = "&";
        pair_kind = sct_pkg::K_AND;
      end
      default: is_pair = 1'b0;
    endcase
  end

  // next-state and token for this pass
  always_comb begin
    sct_pkg::lex_state_t  s;
    logic [DepthW-1:0]    dep;
    logic [HexW-1:0]      hx;
    logic                 emit;
    sct_pkg::token_kind_e kind;
    logic [62:0]          val;
    logic                 again;
    sct_pkg::token_kind_e qk;
    logic [7:0]           c;
    s     = st_i;
    dep   = depth_i;
    hx    = hex_i;
    emit  = 1'b0;
    kind  = sct_pkg::K_ERROR;
    val   = '0;
    again = 1'b0;
    qk    = sct_pkg::K_IDENT;
    c     = c_i;

    if (eoi_i && (st_i.mode != sct_pkg::M_START)) begin
      // end mark: close the pending token, then come back for the end token
      emit   = fin_emit;
      kind   = fin_kind;
      val    = fin_val;
      s.mode = sct_pkg::M_START;
      again  = 1'b1;
    end else if (is_pair && !((st_i.mode == sct_pkg::M_EXCL) &&
                              (sct_pkg::is_alpha(c) || c == "_"))) begin
      if (c == pair_want) begin
        s      = sct_pkg::take_byte(s, c);
        emit   = 1'b1;
        kind   = pair_kind;
        s.mode = sct_pkg::M_START;
      end else begin
        emit   = fin_emit;
        kind   = fin_kind;
        s.mode = sct_pkg::M_START;
        again  = 1'b1;
      end
    end else begin
      case (st_i.mode)
        sct_pkg::M_START: begin
          s  = sct_pkg::begin_tok(s);
          hx = '0;
          if (eoi_i) begin
            emit = 1'b1;
            kind = sct_pkg::K_END;
          end else if (c == 8'h0A) begin
            s.line = sct_pkg::line_inc(s.line);
            s.nl   = 1'b1;
          end else if (!sct_pkg::is_blank(c)) begin
            s = sct_pkg::take_byte(s, c);
            case (c)
              "+": begin emit = 1'b1; kind = sct_pkg::K_ADD;    end
              "*": begin emit = 1'b1; kind = sct_pkg::K_MUL;    end
              "(": begin emit = 1'b1; kind = sct_pkg::K_LPAR;   end
              ")": begin emit = 1'b1; kind = sct_pkg::K_RPAR;   end
              "{": begin emit = 1'b1; kind = sct_pkg::K_LBRACE; end
              "}": begin emit = 1'b1; kind = sct_pkg::K_RBRACE; end
              ":": begin emit = 1'b1; kind = sct_pkg::K_COLON;  end
              ",": begin emit = 1'b1; kind = sct_pkg::K_COMMA;  end
              "/":  s.mode = sct_pkg::M_SLASH;
              "-":  s.mode = sct_pkg::M_SUB;
              "!":  s.mode = sct_pkg::M_EXCL;
              "=":  s.mode = sct_pkg::M_ASSIGN;
              ">":  s.mode = sct_pkg::M_GT;
              "<":  s.mode = sct_pkg::M_LT;
              "?":  s.mode = sct_pkg::M_QUEST;
              "|":  s.mode = sct_pkg::M_OR;
              "&":  s.mode = sct_pkg::M_AND;
              "_":  s.mode = sct_pkg::M_UNDER;
              "\"": s.mode = sct_pkg::M_STR;
              default: begin
                if (sct_pkg::is_digit(c)) begin
                  s.acc  = {59'b0, c[3:0]};
                  s.mode = sct_pkg::M_INT;
                end else if (sct_pkg::is_alpha(c)) begin
                  s.mode = sct_pkg::M_IDENT;
                end else begin
                  emit = 1'b1;
                  kind = sct_pkg::K_ERROR;
                end
              end
            endcase
          end
        end
        sct_pkg::M_SLASH: begin
          if (c == "/") begin
            s      = sct_pkg::take_byte(s, c);
            s.mode = sct_pkg::M_LINE;
          end else if (c == "*") begin
            s      = sct_pkg::take_byte(s, c);
            dep    = DepthW'(1);
            s.mode = sct_pkg::M_BLOCK;
          end else begin
            emit   = fin_emit;
            kind   = fin_kind;
            s.mode = sct_pkg::M_START;
            again  = 1'b1;
          end
        end
        sct_pkg::M_LINE: begin
          if (c == 8'h0A) begin
            emit   = fin_emit;
            kind   = fin_kind;
            s.mode = sct_pkg::M_START;
            again  = 1'b1;
          end else begin
            s = sct_pkg::take_byte(s, c);
          end
        end
        sct_pkg::M_BLOCK: begin
          s = sct_pkg::take_byte(s, c);
          if (c == "*") s.mode = sct_pkg::M_BSTAR;
          else if (c == "/") s.mode = sct_pkg::M_BSLASH;
        end
        sct_pkg::M_BSTAR: begin
          s = sct_pkg::take_byte(s, c);
          if (c == "/") begin
            if (dep != '0) dep = dep - 1'b1;
            if (dep == '0) begin
              emit   = 1'b1;
              kind   = sct_pkg::K_BLOCKCOM;
              s.mode = sct_pkg::M_START;
            end else begin
              s.mode = sct_pkg::M_BLOCK;
            end
          end else if (c != "*") begin
            s.mode = sct_pkg::M_BLOCK;
          end
        end
        sct_pkg::M_BSLASH: begin
          s = sct_pkg::take_byte(s, c);
          if (c == "*") begin
            if (dep < DepthW'(MAX_NEST)) dep = dep + 1'b1;
            s.mode = sct_pkg::M_BLOCK;
          end else if (c != "/") begin
            s.mode = sct_pkg::M_BLOCK;
          end
        end
        sct_pkg::M_EXCL: begin
          // bang before a word
          emit   = 1'b1;
          kind   = sct_pkg::K_NOT;
          s.mode = sct_pkg::M_START;
          again  = 1'b1;
        end
        sct_pkg::M_UNDER: begin
          if (c == " " || c == ":") begin
            emit   = 1'b1;
            kind   = sct_pkg::K_UNDER;
            s.mode = sct_pkg::M_START;
          end else begin
            s.mode = sct_pkg::M_IDENT;
          end
          again = 1'b1;
        end
        sct_pkg::M_IDENT: begin
          if (sct_pkg::is_word(c)) begin
            s = sct_pkg::take_byte(s, c);
          end else if (c == "?" && s.wlen < 16'(sct_pkg::WINDOW)) begin
            // try the optional-type keyword
            s.window[s.wlen[2:0]] = "?";
            qk = sct_pkg::word_kind(s.window, s.wlen + 16'd1);
            if (qk != sct_pkg::K_IDENT) begin
              s      = sct_pkg::take_byte(s, c);
              emit   = 1'b1;
              kind   = qk;
              s.mode = sct_pkg::M_START;
            end else begin
              emit   = fin_emit;
              kind   = fin_kind;
              s.mode = sct_pkg::M_START;
              again  = 1'b1;
            end
          end else begin
            emit   = fin_emit;
            kind   = fin_kind;
            s.mode = sct_pkg::M_START;
            again  = 1'b1;
          end
        end
        sct_pkg::M_INT: begin
          if (sct_pkg::is_digit(c)) begin
            s     = sct_pkg::take_byte(s, c);
            s.acc = sct_pkg::acc_step(st_i.acc, c);
          end else if (c == ".") begin
            s      = sct_pkg::take_byte(s, c);
            s.mode = sct_pkg::M_DOT;
          end else if (c == "e" || c == "E") begin
            s      = sct_pkg::take_byte(s, c);
            s.mode = sct_pkg::M_EMARK;
          end else begin
            emit   = fin_emit;
            kind   = fin_kind;
            val    = fin_val;
            s.mode = sct_pkg::M_START;
            again  = 1'b1;
          end
        end
        sct_pkg::M_DOT, sct_pkg::M_ESIGN: begin
          if (sct_pkg::is_digit(c)) begin
            s      = sct_pkg::take_byte(s, c);
            s.mode = (st_i.mode == sct_pkg::M_DOT) ? sct_pkg::M_FRAC : sct_pkg::M_EXP;
          end else begin
            emit   = fin_emit;
            kind   = fin_kind;
            s.mode = sct_pkg::M_START;
            again  = 1'b1;
          end
        end
        sct_pkg::M_FRAC: begin
          if (sct_pkg::is_digit(c)) begin
            s = sct_pkg::take_byte(s, c);
          end else if (c == "e" || c == "E") begin
            s      = sct_pkg::take_byte(s, c);
            s.mode = sct_pkg::M_EMARK;
          end else begin
            emit   = fin_emit;
            kind   = fin_kind;
            s.mode = sct_pkg::M_START;
            again  = 1'b1;
          end
        end
        sct_pkg::M_EMARK: begin
          if (c == "+" || c == "-") begin
            s      = sct_pkg::take_byte(s, c);
            s.mode = sct_pkg::M_ESIGN;
          end else if (sct_pkg::is_digit(c)) begin
            s      = sct_pkg::take_byte(s, c);
            s.mode = sct_pkg::M_EXP;
          end else begin
            emit   = fin_emit;
            kind   = fin_kind;
            s.mode = sct_pkg::M_START;
            again  = 1'b1;
          end
        end
        sct_pkg::M_EXP: begin
          if (sct_pkg::is_digit(c)) begin
            s = sct_pkg::take_byte(s, c);
          end else begin
            emit   = fin_emit;
            kind   = fin_kind;
            s.mode = sct_pkg::M_START;
            again  = 1'b1;
          end
        end
        sct_pkg::M_STR: begin
          s = sct_pkg::take_byte(s, c);
          if (c == "\"") begin
            emit   = 1'b1;
            kind   = sct_pkg::K_STRING;
            s.mode = sct_pkg::M_START;
          end else if (c == "\\") begin
            s.mode = sct_pkg::M_ESC;
          end
        end
        sct_pkg::M_ESC: begin
          s = sct_pkg::take_byte(s, c);
          if (c inside {"\\", "\"", "n", "r", "t"}) begin
            s.mode = sct_pkg::M_STR;
          end else if (c == "u") begin
            hx     = '0;
            s.mode = sct_pkg::M_UNI_U;
          end else begin
            emit   = 1'b1;
            kind   = sct_pkg::K_ERROR;
            s.mode = sct_pkg::M_START;
          end
        end
        sct_pkg::M_UNI_U: begin
          s = sct_pkg::take_byte(s, c);
          if (c == "{") begin
            s.mode = sct_pkg::M_UNI_HEX;
          end else begin
            emit   = 1'b1;
            kind   = sct_pkg::K_ERROR;
            s.mode = sct_pkg::M_START;
          end
        end
        sct_pkg::M_UNI_HEX: begin
          s = sct_pkg::take_byte(s, c);
          if (sct_pkg::is_hex(c) && hx < HexW'(MAX_HEX_DIGITS)) begin
            hx = hx + 1'b1;
          end else if (c == "}" && hx != '0) begin
            s.mode = sct_pkg::M_STR;
          end else begin
            emit   = 1'b1;
            kind   = sct_pkg::K_ERROR;
            s.mode = sct_pkg::M_START;
          end
        end
        default: begin
          s.mode = sct_pkg::M_START;
          again  = 1'b1;
        end
      endcase
    end

    tok_o = sct_pkg::make_token(s, kind, val);
    if (emit) s.nl = 1'b0;

    // an idle pass leaves everything as it was
    if (!act_i) begin
      s     = st_i;
      dep   = depth_i;
      hx    = hex_i;
      emit  = 1'b0;
      again = 1'b0;
    end
    st_o    = s;
    depth_o = dep;
    hex_o   = hx;
    emit_o  = emit;
    again_o = again;
  end

endmodule

`default_nettype wire

>>> rtl/sct_lexer.sv
// Scanner state registers and the chain of scanning passes for one byte.
// Uses sct_pkg and sct_lex_step.
`timescale 1ns / 1ps
`default_nettype none

module sct_lexer #(
  parameter int unsigned MAX_NEST       = 255,
  parameter int unsigned MAX_HEX_DIGITS = 8
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire sct_pkg::in_t                           item_i,
  input  wire logic                                   commit_i,
  output logic [1:0]                                  n_emit_o,
  output sct_pkg::out_t [sct_pkg::MAX_TOKENS-1:0]     toks_o
);

  localparam int unsigned DepthW = $clog2(MAX_NEST + 1);
  localparam int unsigned HexW   = $clog2(MAX_HEX_DIGITS + 1);
  localparam int unsigned Passes = sct_pkg::MAX_TOKENS;

  sct_pkg::lex_state_t state_q, state_d;
  logic [DepthW-1:0]   depth_q;
  logic [HexW-1:0]     hex_q;

  sct_pkg::lex_state_t                    st   [Passes+1];
  logic [DepthW-1:0]                      dep  [Passes+1];
  logic [HexW-1:0]                        hx   [Passes+1];
  logic [Passes:0]                        act;
  logic [Passes-1:0]                      emit;
  logic [Passes-1:0]                      again;
  sct_pkg::out_t                          tok  [Passes];

  assign st[0]  = state_q;
  assign dep[0] = depth_q;
  assign hx[0]  = hex_q;
  assign act[0] = 1'b1;

  // a byte re-examined after a completed token takes the next pass
  for (genvar k = 0; k < Passes; k++) begin : g_pass
    sct_lex_step #(
      .MAX_NEST      (MAX_NEST),
      .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
    ) u_step (
      .act_i  (act[k]),
      .c_i    (item_i.code_byte),
      .eoi_i  (item_i.end_of_input),
      .st_i   (st[k]),
      .depth_i(dep[k]),
      .hex_i  (hx[k]),
      .st_o   (st[k+1]),
      .depth_o(dep[k+1]),
      .hex_o  (hx[k+1]),
      .emit_o (emit[k]),
      .tok_o  (tok[k]),
      .again_o(again[k])
    );
    assign act[k+1] = act[k] & again[k];
  end

  // gather emitted tokens in order and mark the last one
  always_comb begin
    logic [1:0] idx;
    idx    = '0;
    toks_o = '0;
    for (int k = 0; k < Passes; k++) begin
      if (emit[k]) begin
        toks_o[idx] = tok[k];
        idx         = idx + 2'd1;
      end
    end
    if (idx != 2'd0) toks_o[idx - 2'd1].last_of_run = 1'b1;
    n_emit_o = idx;
  end

  // the offset moves past every real byte
  always_comb begin
    state_d = st[Passes];
    if (!item_i.end_of_input && (state_q.offset != {sct_pkg::OFFSET_WIDTH{1'b1}})) begin
      state_d.offset = state_q.offset + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode   <= sct_pkg::M_START;
      state_q.window <= '0;
      state_q.wlen   <= '0;
      state_q.acc    <= '0;
      state_q.line   <= sct_pkg::LINE_WIDTH'(1);
      state_q.offset <= '0;
      state_q.tstart <= '0;
      state_q.nl     <= 1'b0;
      depth_q        <= '0;
      hex_q          <= '0;
    end else if (commit_i) begin
      state_q <= state_d;
      depth_q <= dep[Passes];
      hex_q   <= hx[Passes];
    end
  end

endmodule

`default_nettype wire

>>> rtl/sct_tok_fifo.sv
// Token queue between the scanner and the output channel; takes up to three
// tokens a cycle and hands out one. Uses sct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sct_tok_fifo (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [1:0]                           push_n_i,
  input  wire sct_pkg::out_t [sct_pkg::MAX_TOKENS-1:0] push_data_i,
  input  wire logic                                 pop_i,
  output logic                                      valid_o,
  output sct_pkg::out_t                             data_o,
  output logic [2:0]                                free_o
);

  localparam int unsigned Depth = 4;

  sct_pkg::out_t mem_q [Depth];
  logic [1:0]    rd_q, rd_d;
  logic [1:0]    wr_q, wr_d;
  logic [2:0]    cnt_q, cnt_d;

  assign valid_o = (cnt_q != 3'd0);
  assign data_o  = mem_q[rd_q];
  // room counts the slot freed by a pop in the same cycle
  assign free_o  = 3'(Depth) - cnt_q + {2'b0, pop_i};

  assign rd_d  = rd_q + {1'b0, pop_i};
  assign wr_d  = wr_q + push_n_i;
  assign cnt_d = cnt_q + {1'b0, push_n_i} - {2'b0, pop_i};

  // storage
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < sct_pkg::MAX_TOKENS; k++) begin
      if (2'(k) < push_n_i) mem_q[wr_q + 2'(k)] <= push_data_i[k];
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/source_code_tokenizer_unit.sv
// Top level of the source code tokenizer: input register, scanner, token queue.
// Uses sct_pkg, sct_lexer and sct_tok_fifo.
`timescale 1ns / 1ps
`default_nettype none

// The tokenizer takes one source byte (or an end mark) per request and emits
// the tokens it completes, each with kind, line, newline flag, start offset,
// length and integer value; last_of_run marks the final token of a request.
// A request is held in an input register and scanned combinationally, so one
// byte enters every clock while the four-entry token queue has room for the
// tokens that byte produces; the tokens of a request leave the output one at a
// time, and the end mark gives one or two. An accepted byte passes through the
// input register and then the token queue before its first token is offered.
module source_code_tokenizer_unit #(
  parameter int unsigned MAX_NEST       = 255,
  parameter int unsigned MAX_HEX_DIGITS = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire sct_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output sct_pkg::out_t     out_data_o
);

  logic                                      in_v_q, in_v_d;
  sct_pkg::in_t                              in_q;
  logic                                      adv;
  logic [1:0]                                n_emit;
  sct_pkg::out_t [sct_pkg::MAX_TOKENS-1:0]   toks;
  logic [2:0]                                free;
  logic                                      pop;

  // held request moves on when the queue can take its tokens
  assign adv        = in_v_q && (free >= {1'b0, n_emit});
  assign in_stall_o = in_v_q && !adv;
  assign pop        = out_valid_o && !out_stall_i;

  assign in_v_d = (in_valid_i && !in_stall_o) ? 1'b1 : (adv ? 1'b0 : in_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_data_i;
  end

  sct_lexer #(
    .MAX_NEST      (MAX_NEST),
    .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
  ) u_lexer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (in_q),
    .commit_i(adv),
    .n_emit_o(n_emit),
    .toks_o  (toks)
  );

  sct_tok_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_n_i   (adv ? n_emit : 2'd0),
    .push_data_i(toks),
    .pop_i      (pop),
    .valid_o    (out_valid_o),
    .data_o     (out_data_o),
    .free_o     (free)
  );

  // an end mark always yields at least the end token
  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.end_of_input) |-> (n_emit != 2'd0))
    else $error("end mark produced no token");

  // tokens pushed this cycle are offered next cycle
  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (n_emit != 2'd0)) |=> out_valid_o)
    else $error("queued token not offered");

  // the reported queue room never exceeds five
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free <= 3'd5)
    else $error("token queue room out of range");

endmodule

`default_nettype wire
